// File: rtl/core/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned DigitCount  = 10;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned BcdWidth    = DigitCount * DigitWidth;
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned StepCount   = ValueWidth / BitsPerStep;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNul   = 8'h00;

  // One classified input transaction: sign and unsigned magnitude.
  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } item_t;

  // Finished conversion handed from the converter to the emitter.
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [BcdWidth-1:0] bcd;
  } conv_res_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_DONE
  } conv_state_e;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SIGN,
    E_DIGIT,
    E_NUL
  } emit_state_e;

endpackage

// File: rtl/core/itda_front.sv
// ----------------------------------------------------------------------------
// itda_front
// Accepts input values, splits them into sign and magnitude, and queues them.
// ----------------------------------------------------------------------------
module itda_front #(
  parameter int unsigned Depth = itda_pkg::QueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [itda_pkg::ValueWidth-1:0] value_i,
  output logic                                 item_valid_o,
  output itda_pkg::item_t                      item_o,
  input  logic                                 pop_i
);

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  itda_pkg::item_t                    mem_q [Depth];
  itda_pkg::item_t                    entry;
  logic [itda_pkg::ValueWidth-1:0]    raw;
  logic [PtrWidth-1:0]                wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]                count_q, count_d;
  logic                               push, pop;

  assign raw       = value_i;
  assign entry.neg = raw[itda_pkg::ValueWidth-1];
  // The unsigned magnitude also covers the most negative value.
  assign entry.mag = entry.neg ? (~raw + itda_pkg::ValueWidth'(1)) : raw;

  assign in_stall_o   = (count_q == FullCnt);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntWidth'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// File: rtl/core/itda_conv.sv
// ----------------------------------------------------------------------------
// itda_conv
// Binary to BCD converter: shift-and-add-three, four bits per cycle.
// ----------------------------------------------------------------------------
module itda_conv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  itda_pkg::item_t       item_i,
  output logic                  pop_o,
  output itda_pkg::conv_res_t   res_o,
  input  logic                  take_i
);

  localparam int unsigned StepWidth = $clog2(itda_pkg::StepCount);
  localparam logic [StepWidth-1:0] LastStep = StepWidth'(itda_pkg::StepCount - 1);

  itda_pkg::conv_state_e               state_q, state_d;
  logic [StepWidth-1:0]                step_q, step_d;
  logic                                neg_q, neg_d;
  logic [itda_pkg::ValueWidth-1:0]     mag_q, mag_d, mag_nx;
  logic [itda_pkg::BcdWidth-1:0]       bcd_q, bcd_d, bcd_nx;

  // Four dependent adjust-and-shift steps on the BCD accumulator.
  always_comb begin
    bcd_nx = bcd_q;
    mag_nx = mag_q;
    for (int s = 0; s < itda_pkg::BitsPerStep; s++) begin
      for (int d = 0; d < itda_pkg::DigitCount; d++) begin
        if (bcd_nx[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] >= 4'd5) begin
          bcd_nx[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] =
            bcd_nx[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] + 4'd3;
        end
      end
      {bcd_nx, mag_nx} = {bcd_nx, mag_nx} << 1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itda_pkg::C_IDLE: begin
        if (item_valid_i) begin
          state_d = itda_pkg::C_RUN;
        end
      end
      itda_pkg::C_RUN: begin
        if (step_q == LastStep) begin
          state_d = itda_pkg::C_DONE;
        end
      end
      itda_pkg::C_DONE: begin
        if (take_i) begin
          state_d = itda_pkg::C_IDLE;
        end
      end
      default: state_d = itda_pkg::C_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    pop_o  = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    unique case (state_q)
      itda_pkg::C_IDLE: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          step_d = '0;
          neg_d  = item_i.neg;
          mag_d  = item_i.mag;
          bcd_d  = '0;
        end
      end
      itda_pkg::C_RUN: begin
        step_d = step_q + StepWidth'(1);
        mag_d  = mag_nx;
        bcd_d  = bcd_nx;
      end
      default: ;
    endcase
  end

  // Result fields in declaration order: valid, sign, BCD digits.
  assign res_o = {(state_q == itda_pkg::C_DONE), neg_q, bcd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itda_pkg::C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
  end

endmodule

// File: rtl/core/itda_emit.sv
// ----------------------------------------------------------------------------
// itda_emit
// Walks a finished BCD result, issuing sign, digits and NUL one per cycle unless stalled.
// ----------------------------------------------------------------------------
module itda_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itda_pkg::conv_res_t   res_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            char_out_o,
  output logic                  last_o
);

  localparam int unsigned IdxWidth = $clog2(itda_pkg::DigitCount);

  itda_pkg::emit_state_e           state_q, state_d;
  logic [itda_pkg::BcdWidth-1:0]   bcd_q;
  logic [IdxWidth-1:0]             idx_q, idx_d, top;
  logic [itda_pkg::DigitWidth-1:0] digit;
  logic                            adv, load;
  logic                            out_valid_q, out_valid_d;
  logic [7:0]                      char_q, char_d;
  logic                            last_q, last_d;

  // Position of the most significant nonzero digit; zero gives one digit.
  always_comb begin
    top = '0;
    for (int d = 0; d < itda_pkg::DigitCount; d++) begin
      if (res_i.bcd[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] != '0) begin
        top = IdxWidth'(d);
      end
    end
  end

  assign digit = bcd_q[idx_q*itda_pkg::DigitWidth +: itda_pkg::DigitWidth];
  assign adv   = !out_valid_q || !out_stall_i;
  assign load  = (state_q == itda_pkg::E_IDLE) && res_i.valid;
  assign take_o = load;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itda_pkg::E_IDLE: begin
        if (res_i.valid) begin
          state_d = res_i.neg ? itda_pkg::E_SIGN : itda_pkg::E_DIGIT;
        end
      end
      itda_pkg::E_SIGN: begin
        if (adv) begin
          state_d = itda_pkg::E_DIGIT;
        end
      end
      itda_pkg::E_DIGIT: begin
        if (adv && (idx_q == '0)) begin
          state_d = itda_pkg::E_NUL;
        end
      end
      itda_pkg::E_NUL: begin
        if (adv) begin
          state_d = itda_pkg::E_IDLE;
        end
      end
      default: state_d = itda_pkg::E_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      itda_pkg::E_IDLE: begin
        if (res_i.valid) begin
          idx_d = top;
        end
      end
      itda_pkg::E_SIGN: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = itda_pkg::CharMinus;
          last_d      = 1'b0;
        end
      end
      itda_pkg::E_DIGIT: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = itda_pkg::CharZero + {4'b0000, digit};
          last_d      = 1'b0;
          if (idx_q != '0) begin
            idx_d = idx_q - IdxWidth'(1);
          end
        end
      end
      itda_pkg::E_NUL: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = itda_pkg::CharNul;
          last_d      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itda_pkg::E_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
    if (load) begin
      bcd_q <= res_i.bcd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / value_i): one transaction is a
//   32-bit two's-complement value. It is taken when in_valid_i is high and
//   in_stall_o is low. The front splits it into sign and magnitude and puts
//   it into a two-entry queue; in_stall_o rises only when that queue is full.
//   Output channel (out_valid_o / out_stall_i / char_out_o / last_o): each
//   transaction is one character: '-' for negatives, the digits most
//   significant first without leading zeros ("0" for zero), then a NUL byte
//   with last_o set. One value yields 2 to 12 transactions.
//   From acceptance to the first character a value passes queue write,
//   converter load, eight conversion steps, handoff and emit. The converter
//   handles four magnitude bits per cycle, and the emitter issues one
//   character per cycle while the output is not stalled, after loading a
//   result; the converter can convert the next value meanwhile.
//   A stall on the output holds the character register; the converter and
//   the queue keep working until they fill. Reset empties the queue and
//   returns both back-end state machines to idle with no output valid.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
  parameter int unsigned QueueDepth = itda_pkg::QueueDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [itda_pkg::ValueWidth-1:0] value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [7:0]                             char_out_o,
  output logic                                   last_o
);

  logic                item_valid;
  itda_pkg::item_t     item;
  logic                pop;
  itda_pkg::conv_res_t res;
  logic                take;

  // Front: accept, classify, queue.
  itda_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  // Back, first half: binary magnitude to BCD digits.
  itda_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .res_o        (res),
    .take_i       (take)
  );

  // Back, second half: character sequencing behind an output register.
  itda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/core/itda_checker.sv
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
module itda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic       last_o
);

  // A stalled output transaction stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_out_o) && $stable(last_o))
    else $error("output changed while stalled");

  // The last mark goes only with the NUL byte, and NUL only with the mark.
  a_last_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (char_out_o == itda_pkg::CharNul)))
    else $error("last mark and NUL byte disagree");

  // Every other character is a minus sign or a digit.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |->
      (char_out_o == itda_pkg::CharMinus) ||
      ((char_out_o >= itda_pkg::CharZero) && (char_out_o <= itda_pkg::CharZero + 8'd9)))
    else $error("unexpected character");

  // A minus sign is followed by a nonzero leading digit.
  a_sign_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (char_out_o == itda_pkg::CharMinus) |=>
      !out_valid_o ||
      ((char_out_o >= itda_pkg::CharZero + 8'd1) && (char_out_o <= itda_pkg::CharZero + 8'd9)))
    else $error("minus sign not followed by a leading digit");

  // The text of a new value never starts with a terminator.
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !(out_valid_o && last_o))
    else $error("empty text emitted");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);
